// ===== rtl/uje_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 escaper.
// No dependencies; used by every module under rtl/.
package uje_pkg;

  localparam int MaxBytes   = 6;
  localparam int QueueDepth = 4;
  localparam int IdxW       = $clog2(MaxBytes);
  localparam int CntW       = $clog2(MaxBytes + 1);
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase  = 21'h10000;

  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] Quote     = 8'h22;
  localparam logic [7:0] LetterN   = 8'h6E;
  localparam logic [7:0] LetterR   = 8'h72;
  localparam logic [7:0] LineFeed  = 8'h0A;
  localparam logic [7:0] CarRet    = 8'h0D;

  // One queue entry: the bytes caused by one item, bytes[0] first.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
  } cmd_t;

endpackage

// ===== rtl/uje_front.sv =====
// Front end: classifies each code unit, tracks a held high surrogate and
// builds the full byte list for the item. Depends on uje_pkg.
module uje_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [15:0]       code_unit,
  input  logic              escape_line_breaks,
  input  logic              end_of_string,
  input  logic              q_full,
  output logic              q_wr,
  output uje_pkg::cmd_t     q_wdata
);

  logic       high_held;
  logic       high_held_next;
  logic [9:0] high_payload;
  logic [9:0] high_payload_next;

  logic       is_high;
  logic       is_low;
  logic       accept;
  logic [15:0] flush_cu;
  logic [20:0] supp_cp;

  logic [3:0][7:0] seg_b;
  logic [2:0]      nb;

  assign accept  = push && !q_full;
  assign is_high = (code_unit >= uje_pkg::HighFirst) && (code_unit <= uje_pkg::HighLast);
  assign is_low  = (code_unit >= uje_pkg::LowFirst) && (code_unit <= uje_pkg::LowLast);
  assign flush_cu = uje_pkg::HighFirst | {6'd0, high_payload};
  assign supp_cp  = uje_pkg::SuppBase + {1'b0, high_payload, 10'd0} + {11'd0, code_unit[9:0]};

  // Bytes of the new unit itself (second segment), up to four.
  always_comb begin
    seg_b = '0;
    nb    = 3'd0;
    if (high_held && is_low) begin
      seg_b[0] = {5'b11110, supp_cp[20:18]};
      seg_b[1] = {2'b10, supp_cp[17:12]};
      seg_b[2] = {2'b10, supp_cp[11:6]};
      seg_b[3] = {2'b10, supp_cp[5:0]};
      nb       = 3'd4;
    end else if (is_high && !end_of_string) begin
      nb = 3'd0;
    end else if (code_unit <= 16'h007F) begin
      if (code_unit inside {[16'h0000:16'h0008], 16'h000B, 16'h000C,
                            [16'h000E:16'h001F], 16'h007F}) begin
        nb = 3'd0;
      end else if (code_unit[7:0] == uje_pkg::Quote ||
                   code_unit[7:0] == uje_pkg::Backslash) begin
        seg_b[0] = uje_pkg::Backslash;
        seg_b[1] = code_unit[7:0];
        nb       = 3'd2;
      end else if (escape_line_breaks && code_unit[7:0] == uje_pkg::LineFeed) begin
        seg_b[0] = uje_pkg::Backslash;
        seg_b[1] = uje_pkg::LetterN;
        nb       = 3'd2;
      end else if (escape_line_breaks && code_unit[7:0] == uje_pkg::CarRet) begin
        seg_b[0] = uje_pkg::Backslash;
        seg_b[1] = uje_pkg::LetterR;
        nb       = 3'd2;
      end else begin
        seg_b[0] = code_unit[7:0];
        nb       = 3'd1;
      end
    end else if (code_unit <= 16'h07FF) begin
      seg_b[0] = {3'b110, code_unit[10:6]};
      seg_b[1] = {2'b10, code_unit[5:0]};
      nb       = 3'd2;
    end else begin
      // three-byte form; covers lone surrogates too
      seg_b[0] = {4'b1110, code_unit[15:12]};
      seg_b[1] = {2'b10, code_unit[11:6]};
      seg_b[2] = {2'b10, code_unit[5:0]};
      nb       = 3'd3;
    end
  end

  // Prefix the flushed high surrogate when the new unit does not pair with it.
  always_comb begin
    q_wdata = '0;
    if (high_held && !is_low) begin
      q_wdata.bytes[0] = {4'b1110, flush_cu[15:12]};
      q_wdata.bytes[1] = {2'b10, flush_cu[11:6]};
      q_wdata.bytes[2] = {2'b10, flush_cu[5:0]};
      q_wdata.bytes[3] = seg_b[0];
      q_wdata.bytes[4] = seg_b[1];
      q_wdata.bytes[5] = seg_b[2];
      q_wdata.cnt      = uje_pkg::CntW'(nb) + uje_pkg::CntW'(3);
    end else begin
      q_wdata.bytes[0] = seg_b[0];
      q_wdata.bytes[1] = seg_b[1];
      q_wdata.bytes[2] = seg_b[2];
      q_wdata.bytes[3] = seg_b[3];
      q_wdata.cnt      = uje_pkg::CntW'(nb);
    end
  end

  assign q_wr = accept && (q_wdata.cnt != '0);

  always_comb begin
    high_held_next    = high_held;
    high_payload_next = high_payload;
    if (accept) begin
      if (is_high && !(high_held && is_low) && !end_of_string) begin
        high_held_next    = 1'b1;
        high_payload_next = code_unit[9:0];
      end else begin
        high_held_next    = 1'b0;
        high_payload_next = 10'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_held    <= 1'b0;
      high_payload <= 10'd0;
    end else begin
      high_held    <= high_held_next;
      high_payload <= high_payload_next;
    end
  end

endmodule

// ===== rtl/uje_queue.sv =====
// Short queue of per-item byte lists between front and back ends.
// Depends on uje_pkg.
module uje_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  uje_pkg::cmd_t wdata,
  output logic          full,
  input  logic          rd,
  output logic          valid,
  output uje_pkg::cmd_t rdata
);

  uje_pkg::cmd_t mem [uje_pkg::QueueDepth];

  logic [uje_pkg::QPtrW-1:0] wptr;
  logic [uje_pkg::QPtrW-1:0] rptr;
  logic [uje_pkg::QCntW-1:0] count;

  assign full  = (count == uje_pkg::QCntW'(uje_pkg::QueueDepth));
  assign valid = (count != '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/uje_back.sv =====
// Back end: walks the head entry of the queue one byte per cycle into the
// result register, whenever that register is empty or popped. Depends on uje_pkg.
module uje_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  uje_pkg::cmd_t q_head,
  output logic          q_rd,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          last_of_run
);

  logic                     out_valid;
  logic [uje_pkg::IdxW-1:0] idx;
  logic                     load;
  logic                     at_end;

  assign load   = q_valid && (!out_valid || pop);
  assign at_end = (idx == uje_pkg::IdxW'(q_head.cnt - 1'b1));
  assign q_rd   = load && at_end;
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= q_head.bytes[idx];
      last_of_run <= at_end;
    end
  end

endmodule

// ===== rtl/utf16_to_utf8_json_escaper_unit.sv =====
// Top level of the UTF-16 to UTF-8 JSON escaper.
// Depends on uje_pkg, uje_front, uje_queue and uje_back.
//
// Usage:
//   Input queue port: drive code_unit, escape_line_breaks and end_of_string
//   with push; the item is taken at a clock edge with push high, full low.
//   Result queue port: while empty is low, out_byte/last_of_run show the
//   oldest byte; it is taken at an edge with pop high. last_of_run marks
//   the final byte caused by one item; items that cause no byte give none.
//   Path: an accepted item is written into the queue; its first byte is loaded
//   from the queue head once the result register is empty or popped.
//   Throughput: the back end emits one byte per cycle while pop is high; an item causes 0 to 6 bytes.
//   The front end takes one item per cycle while the four-entry queue
//   between the two has room; full rises only when that queue is full.
//   When the receiver stalls, the current byte holds, the queue fills and
//   then full stops further input.
//   Reset (rst, synchronous): empties the queue, drops any held high
//   surrogate and marks the result register empty.
module utf16_to_utf8_json_escaper_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit,
  input  logic        escape_line_breaks,
  input  logic        end_of_string,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_run
);

  logic          q_wr;
  logic          q_full;
  logic          q_rd;
  logic          q_valid;
  uje_pkg::cmd_t q_wdata;
  uje_pkg::cmd_t q_head;

  assign full = q_full;

  uje_front u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .code_unit          (code_unit),
    .escape_line_breaks (escape_line_breaks),
    .end_of_string      (end_of_string),
    .q_full             (q_full),
    .q_wr               (q_wr),
    .q_wdata            (q_wdata)
  );

  uje_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .valid (q_valid),
    .rdata (q_head)
  );

  uje_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  // front never writes into a full queue
  assert property (@(posedge clk) disable iff (rst) !(q_wr && q_full))
    else $error("write into full queue");

  // back never retires an entry that is not there
  assert property (@(posedge clk) disable iff (rst) q_rd |-> q_valid)
    else $error("read from empty queue");

  // queued entries always carry at least one byte
  assert property (@(posedge clk) disable iff (rst) q_valid |-> (q_head.cnt != '0))
    else $error("empty entry in queue");

  // a byte that closes its item retires the head entry in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    (q_rd && !rst) |=> (!empty && last_of_run))
    else $error("item end lost");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the UTF-16 to UTF-8 JSON escaper.
// Predicts each output byte from the code units sent and checks the byte stream.
// Depends on uje_pkg and utf16_to_utf8_json_escaper_unit.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } utf8_byte_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [15:0] code_unit;
  logic        escape_line_breaks;
  logic        end_of_string;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        last_of_run;

  // predictor state: a high surrogate waiting for its partner
  bit          hi_pending;
  logic [9:0]  hi_bits;

  utf8_byte_t  utf8_expect_q[$];
  logic [7:0]  run_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_seq;
  int hold_len;
  int err_cnt = 0;
  int units_sent;
  int bytes_checked = 0;
  int full_stalls;

  utf16_to_utf8_json_escaper_unit dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .code_unit          (code_unit),
    .escape_line_breaks (escape_line_breaks),
    .end_of_string      (end_of_string),
    .empty              (empty),
    .pop                (pop),
    .out_byte           (out_byte),
    .last_of_run        (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (err_cnt < 20) begin
      $display("tb: mismatch on %s: got %02h want %02h at %0t", what, got, want, $realtime);
    end
    err_cnt++;
  endtask

  function automatic void put_three(input logic [15:0] cp);
    run_q.push_back({4'hE, cp[15:12]});
    run_q.push_back({2'b10, cp[11:6]});
    run_q.push_back({2'b10, cp[5:0]});
  endfunction

  // Advance the predictor by one code unit and queue the bytes it causes.
  function automatic void encode_unit(input logic [15:0] cu, input logic esc,
                                      input logic eos);
    bit          is_hi;
    bit          is_lo;
    bit          done;
    logic [20:0] cp;
    utf8_byte_t  b;
    is_hi = (cu >= uje_pkg::HighFirst) && (cu <= uje_pkg::HighLast);
    is_lo = (cu >= uje_pkg::LowFirst) && (cu <= uje_pkg::LowLast);
    done  = 1'b0;
    run_q.delete();
    if (hi_pending) begin
      hi_pending = 1'b0;
      if (is_lo) begin
        cp = uje_pkg::SuppBase + {1'b0, hi_bits, 10'b0} + {5'b0, cu - uje_pkg::LowFirst};
        run_q.push_back({5'b11110, cp[20:18]});
        run_q.push_back({2'b10, cp[17:12]});
        run_q.push_back({2'b10, cp[11:6]});
        run_q.push_back({2'b10, cp[5:0]});
        done = 1'b1;
      end else begin
        put_three(uje_pkg::HighFirst | {6'b0, hi_bits});
      end
      hi_bits = '0;
    end
    if (!done) begin
      if (is_hi) begin
        if (eos) begin
          put_three(cu);
        end else begin
          hi_pending = 1'b1;
          hi_bits    = cu[9:0];
        end
      end else if (cu <= 16'h007F) begin
        if (cu <= 16'h0008 || cu == 16'h000B || cu == 16'h000C ||
            (cu >= 16'h000E && cu <= 16'h001F) || cu == 16'h007F) begin
          // control character: dropped
        end else if (cu[7:0] == uje_pkg::Quote || cu[7:0] == uje_pkg::Backslash) begin
          run_q.push_back(uje_pkg::Backslash);
          run_q.push_back(cu[7:0]);
        end else if (esc && cu[7:0] == uje_pkg::LineFeed) begin
          run_q.push_back(uje_pkg::Backslash);
          run_q.push_back(uje_pkg::LetterN);
        end else if (esc && cu[7:0] == uje_pkg::CarRet) begin
          run_q.push_back(uje_pkg::Backslash);
          run_q.push_back(uje_pkg::LetterR);
        end else begin
          run_q.push_back(cu[7:0]);
        end
      end else if (cu <= 16'h07FF) begin
        run_q.push_back({3'b110, cu[10:6]});
        run_q.push_back({2'b10, cu[5:0]});
      end else begin
        put_three(cu);
      end
    end
    foreach (run_q[i]) begin
      b.data = run_q[i];
      b.last = (i == run_q.size() - 1);
      utf8_expect_q.push_back(b);
    end
  endfunction

  // Offer one item; push stays high on return so back-to-back items need no gap.
  task automatic send_unit(input logic [15:0] cu, input logic esc, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push               <= 1'b1;
    code_unit          <= cu;
    escape_line_breaks <= esc;
    end_of_string      <= eos;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    encode_unit(cu, esc, eos);
    units_sent++;
  endtask

  task automatic wait_drained();
    int n;
    push <= 1'b0;
    for (n = 0; utf8_expect_q.size() != 0 && n < 50000; n++) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic test_ascii_escapes();
    send_unit(16'h0041, 1'b0, 1'b0);
    send_unit(16'h0022, 1'b0, 1'b0);
    send_unit(16'h005C, 1'b1, 1'b0);
    send_unit(16'h000A, 1'b0, 1'b0);
    send_unit(16'h000A, 1'b1, 1'b0);
    send_unit(16'h000D, 1'b0, 1'b0);
    send_unit(16'h000D, 1'b1, 1'b0);
    send_unit(16'h0009, 1'b1, 1'b0);
    // zero is only a dropped control, not a terminator
    send_unit(16'h0000, 1'b0, 1'b0);
    send_unit(16'h007F, 1'b0, 1'b0);
    send_unit(16'h001F, 1'b1, 1'b0);
    send_unit(16'h0020, 1'b0, 1'b1);
  endtask

  task automatic test_multibyte();
    send_unit(16'h0080, 1'b0, 1'b0);
    send_unit(16'h07FF, 1'b0, 1'b0);
    send_unit(16'h0800, 1'b1, 1'b0);
    send_unit(16'hFFFF, 1'b0, 1'b1);
  endtask

  task automatic test_surrogates();
    send_unit(16'hD800, 1'b0, 1'b0);
    send_unit(16'hDC00, 1'b0, 1'b1);
    send_unit(16'hDBFF, 1'b1, 1'b0);
    send_unit(16'hDFFF, 1'b0, 1'b1);
    // held high followed by a plain unit flushes as three bytes
    send_unit(16'hDABC, 1'b0, 1'b0);
    send_unit(16'h0041, 1'b0, 1'b1);
    send_unit(16'hDBFF, 1'b0, 1'b1);
    send_unit(16'hDC00, 1'b0, 1'b1);
    send_unit(16'hD800, 1'b0, 1'b0);
    send_unit(16'hDBFF, 1'b0, 1'b0);
    send_unit(16'hDFFF, 1'b1, 1'b1);
  endtask

  // Receiver stops for a long stretch while input keeps coming, so full rises.
  task automatic test_backpressure();
    int saved;
    saved         = send_idle_pct;
    send_idle_pct = 0;
    hold_len      = 120;
    hold_seq++;
    for (int i = 0; i < 20; i++) begin
      send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), 1'b0, (i == 19));
    end
    send_idle_pct = saved;
    wait_drained();
  endtask

  task automatic send_random_string();
    logic [15:0] units[$];
    int          len;
    int          r;
    logic        esc;
    len = $urandom_range(1, 8);
    esc = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 35) begin
        units.push_back(16'($urandom_range(16'h0020, 16'h007E)));
      end else if (r < 45) begin
        units.push_back(16'($urandom_range(16'h0000, 16'h007F)));
      end else if (r < 50) begin
        case ($urandom_range(4))
          0: units.push_back({8'h00, uje_pkg::Quote});
          1: units.push_back({8'h00, uje_pkg::Backslash});
          2: units.push_back({8'h00, uje_pkg::LineFeed});
          3: units.push_back({8'h00, uje_pkg::CarRet});
          default: units.push_back(16'h0009);
        endcase
      end else if (r < 60) begin
        units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
      end else if (r < 72) begin
        if ($urandom_range(1)) units.push_back(16'($urandom_range(16'h0800, 16'hD7FF)));
        else units.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
      end else if (r < 90) begin
        units.push_back(16'($urandom_range(uje_pkg::HighFirst, uje_pkg::HighLast)));
        units.push_back(16'($urandom_range(uje_pkg::LowFirst, uje_pkg::LowLast)));
      end else if (r < 95) begin
        units.push_back(16'($urandom_range(uje_pkg::HighFirst, uje_pkg::HighLast)));
      end else begin
        units.push_back(16'($urandom_range(uje_pkg::LowFirst, uje_pkg::LowLast)));
      end
    end
    foreach (units[i]) begin
      send_unit(units[i], esc, (i == units.size() - 1));
    end
  endtask

  task automatic test_random_text(input int snd_pct, input int rcv_pct, input int n);
    int start;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start = units_sent;
    while (units_sent - start < n) begin
      if ($urandom_range(99) < 15) begin
        send_unit(16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else begin
        send_random_string();
      end
    end
    wait_drained();
  endtask

  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    pop       = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_left = hold_len;
        hold_seen = hold_seq;
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_out
    utf8_byte_t want;
    if (!rst && pop && !empty) begin
      if (utf8_expect_q.size() == 0) begin
        report_mismatch("unexpected byte", out_byte, 8'h00);
      end else begin
        want = utf8_expect_q.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (last_of_run !== want.last) begin
          report_mismatch("last_of_run", {7'b0, last_of_run}, {7'b0, want.last});
        end
      end
      bytes_checked++;
    end
  end

  initial begin
    rst                = 1'b1;
    push               = 1'b0;
    code_unit          = '0;
    escape_line_breaks = 1'b0;
    end_of_string      = 1'b0;
    hi_pending         = 1'b0;
    hi_bits            = '0;
    hold_seq           = 0;
    hold_len           = 0;
    units_sent         = 0;
    full_stalls        = 0;
    send_idle_pct      = 29;
    recv_idle_pct      = 69;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ascii_escapes();
    test_multibyte();
    test_surrogates();
    wait_drained();
    test_backpressure();
    test_random_text(29, 69, 65);
    test_random_text(69, 29, 65);
    test_random_text(0, 0, 65);

    $display("tb: %0d code units sent (escapes, multibyte, surrogates, random text)",
             units_sent);
    $display("tb: %0d bytes checked, %0d cycles with input held off by full",
             bytes_checked, full_stalls);
    if (err_cnt == 0 && utf8_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
